@@ src/afifo_pkg.sv @@
package afifo_pkg;

  // Fixed frame geometry of the ports.
  localparam int LANES    = 8;
  localparam int SAMPLE_W = 16;
  localparam int OCC_W    = 11;
  localparam int STAT_W   = 64;
  localparam int GEN_W    = 32;

  // Register file geometry.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int CHAN_W     = 4;
  localparam int FRAMES_W   = 11;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 2'd1;

  // Register reset values.
  localparam int FRAMES_RST = 1024;

  // Operation codes.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;
  localparam logic [1:0] OP_STAT  = 2'd3;

  // Statistic selections.
  localparam logic [2:0] STAT_WRITTEN  = 3'd0;
  localparam logic [2:0] STAT_READ     = 3'd1;
  localparam logic [2:0] STAT_OVERRUN  = 3'd2;
  localparam logic [2:0] STAT_UNDERRUN = 3'd3;
  localparam logic [2:0] STAT_GEN      = 3'd4;

  typedef logic [LANES-1:0][SAMPLE_W-1:0] frame_t;

  // One decoded command, passed from the front end to the back end.
  typedef struct packed {
    logic       is_write;
    logic       is_read;
    logic       is_flush;
    logic       is_stat;
    frame_t     samples;
    logic       pad_req;
    logic [2:0] stat_select;
  } cmd_t;

endpackage

@@ src/afifo_front.sv @@
module afifo_front import afifo_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic [1:0]    in_operation,
  input  frame_t        in_samples,
  input  logic          in_pad_req,
  input  logic [2:0]    in_stat_select,
  output logic          cmd_valid,
  output cmd_t          cmd
);

  localparam int QDEPTH = 2;

  cmd_t       q_r [QDEPTH];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       push;
  logic       pop;
  cmd_t       decoded;

  // Classify the incoming item by its operation code.
  always_comb begin
    decoded             = '0;
    decoded.samples     = in_samples;
    decoded.pad_req     = in_pad_req;
    decoded.stat_select = in_stat_select;
    unique case (in_operation)
      OP_WRITE: decoded.is_write = 1'b1;
      OP_READ:  decoded.is_read  = 1'b1;
      OP_FLUSH: decoded.is_flush = 1'b1;
      OP_STAT:  decoded.is_stat  = 1'b1;
      default:  decoded.is_stat  = 1'b1;
    endcase
  end

  // The back end takes one command every cycle, so the queue drains whenever it holds one.
  assign busy      = (count_r == 2'(QDEPTH));
  assign push      = start && !busy;
  assign pop       = (count_r != 2'd0);
  assign cmd_valid = pop;
  assign cmd       = q_r[rd_ptr_r];

  // Queue pointers and fill level.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= decoded;
    end
  end

endmodule

@@ src/afifo_back.sv @@
module afifo_back import afifo_pkg::*; #(
  parameter int STORE_DEPTH  = 1024,
  parameter int MAX_CHANNELS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  cmd_valid,
  input  cmd_t                  cmd,
  output logic                  res_valid,
  output logic                  res_accepted,
  output logic                  res_padded,
  output frame_t                res_samples,
  output logic [OCC_W-1:0]      res_occupancy,
  output logic [STAT_W-1:0]     res_stat_value
);

  localparam int PTR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int CMP_W  = (CNT_W > FRAMES_W) ? CNT_W : FRAMES_W;
  localparam int MEM_W  = MAX_CHANNELS * SAMPLE_W;
  localparam int CAP_RST = (FRAMES_RST > STORE_DEPTH) ? STORE_DEPTH : FRAMES_RST;

  logic [MEM_W-1:0]  mem [STORE_DEPTH];
  logic [MEM_W-1:0]  rd_data_r;
  logic [MEM_W-1:0]  wr_data;

  logic [LANES-1:0]  lane_mask_r;
  logic [LANES-1:0]  lane_mask_nxt;
  logic [CNT_W-1:0]  cap_r;
  logic [CNT_W-1:0]  cap_nxt;

  logic [PTR_W-1:0]  head_r;
  logic [PTR_W-1:0]  head_nxt;
  logic [PTR_W-1:0]  tail_r;
  logic [PTR_W-1:0]  tail_nxt;
  logic [CNT_W-1:0]  fill_r;
  logic [CNT_W-1:0]  fill_nxt;
  logic [STAT_W-1:0] written_r;
  logic [STAT_W-1:0] written_nxt;
  logic [STAT_W-1:0] read_r;
  logic [STAT_W-1:0] read_nxt;
  logic [STAT_W-1:0] overrun_r;
  logic [STAT_W-1:0] overrun_nxt;
  logic [STAT_W-1:0] underrun_r;
  logic [STAT_W-1:0] underrun_nxt;
  logic [GEN_W-1:0]  gen_r;
  logic [GEN_W-1:0]  gen_nxt;

  logic              valid_r;
  logic              acc_r;
  logic              acc_nxt;
  logic              pad_r;
  logic              pad_nxt;
  logic [OCC_W-1:0]  occ_r;
  logic [STAT_W-1:0] stat_r;
  logic [STAT_W-1:0] stat_nxt;
  logic [LANES-1:0]  out_mask_r;

  logic              do_write;
  logic              do_read;
  logic [CMP_W-1:0]  frames_ext;
  logic [CHAN_W-1:0] chan;

  // Next pointer value, wrapping to zero at or past the capacity.
  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W:0] n;
    n = (CNT_W+1)'(p) + 1'b1;
    return (n >= {1'b0, cap}) ? '0 : PTR_W'(n);
  endfunction

  // Clamp register writes into the ranges the datapath uses.
  always_comb begin
    lane_mask_nxt = lane_mask_r;
    cap_nxt       = cap_r;
    frames_ext    = CMP_W'(cfg_data[FRAMES_W-1:0]);
    chan          = cfg_data[CHAN_W-1:0];
    if (chan == '0) begin
      chan = CHAN_W'(1);
    end else if (chan > CHAN_W'(MAX_CHANNELS)) begin
      chan = CHAN_W'(MAX_CHANNELS);
    end
    if (frames_ext == '0) begin
      frames_ext = CMP_W'(1);
    end else if (frames_ext > CMP_W'(STORE_DEPTH)) begin
      frames_ext = CMP_W'(STORE_DEPTH);
    end
    if (cfg_we && (cfg_index == CFG_CHANNEL_COUNT)) begin
      for (int i = 0; i < LANES; i++) begin
        lane_mask_nxt[i] = (CHAN_W'(i) < chan);
      end
    end
    if (cfg_we && (cfg_index == CFG_FRAMES_IN_USE)) begin
      cap_nxt = CNT_W'(frames_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_mask_r <= LANES'(1);
      cap_r       <= CNT_W'(CAP_RST);
    end else begin
      lane_mask_r <= lane_mask_nxt;
      cap_r       <= cap_nxt;
    end
  end

  // Execute one command: ring pointers, fill level, counters and result fields.
  always_comb begin
    do_write     = cmd_valid && cmd.is_write && (fill_r < cap_r);
    do_read      = cmd_valid && cmd.is_read && (fill_r != '0);
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    fill_nxt     = fill_r;
    written_nxt  = written_r;
    read_nxt     = read_r;
    overrun_nxt  = overrun_r;
    underrun_nxt = underrun_r;
    gen_nxt      = gen_r;
    acc_nxt      = do_write || do_read;
    pad_nxt      = 1'b0;
    stat_nxt     = '0;
    if (do_write) begin
      tail_nxt    = advance(tail_r, cap_r);
      fill_nxt    = fill_r + 1'b1;
      written_nxt = written_r + 1'b1;
    end else if (cmd_valid && cmd.is_write) begin
      overrun_nxt = overrun_r + 1'b1;
    end
    if (do_read) begin
      head_nxt = advance(head_r, cap_r);
      fill_nxt = fill_r - 1'b1;
      read_nxt = read_r + 1'b1;
    end else if (cmd_valid && cmd.is_read) begin
      underrun_nxt = underrun_r + 1'b1;
      pad_nxt      = cmd.pad_req;
    end
    if (cmd_valid && cmd.is_flush) begin
      head_nxt = '0;
      tail_nxt = '0;
      fill_nxt = '0;
      gen_nxt  = gen_r + 1'b1;
    end
    if (cmd_valid && cmd.is_stat) begin
      unique case (cmd.stat_select)
        STAT_WRITTEN:  stat_nxt = written_r;
        STAT_READ:     stat_nxt = read_r;
        STAT_OVERRUN:  stat_nxt = overrun_r;
        STAT_UNDERRUN: stat_nxt = underrun_r;
        STAT_GEN:      stat_nxt = STAT_W'(gen_r);
        default:       stat_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      tail_r     <= '0;
      fill_r     <= '0;
      written_r  <= '0;
      read_r     <= '0;
      overrun_r  <= '0;
      underrun_r <= '0;
      gen_r      <= GEN_W'(1);
      valid_r    <= 1'b0;
    end else begin
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      fill_r     <= fill_nxt;
      written_r  <= written_nxt;
      read_r     <= read_nxt;
      overrun_r  <= overrun_nxt;
      underrun_r <= underrun_nxt;
      gen_r      <= gen_nxt;
      valid_r    <= cmd_valid;
    end
  end

  // Result fields registered alongside the memory read.
  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    pad_r      <= pad_nxt;
    occ_r      <= OCC_W'(fill_nxt);
    stat_r     <= stat_nxt;
    out_mask_r <= do_read ? lane_mask_r : '0;
  end

  // Unused lanes are stored as zero.
  always_comb begin
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      wr_data[i*SAMPLE_W +: SAMPLE_W] = lane_mask_r[i] ? cmd.samples[i] : '0;
    end
  end

  // Frame store: one write port at the tail, one registered read port at the head.
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[tail_r] <= wr_data;
    end
    if (do_read) begin
      rd_data_r <= mem[head_r];
    end
  end

  // Lanes beyond the active channel count read as zero.
  always_comb begin
    res_samples = '0;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      res_samples[i] = out_mask_r[i] ? rd_data_r[i*SAMPLE_W +: SAMPLE_W] : '0;
    end
  end

  assign res_valid      = valid_r;
  assign res_accepted   = acc_r;
  assign res_padded     = pad_r;
  assign res_occupancy  = occ_r;
  assign res_stat_value = stat_r;

endmodule

@@ src/audio_frame_fifo.sv @@
// FIFO of multichannel audio frames (up to eight 16-bit samples per frame).
// Input: a command is transferred at a rising edge with start high and busy
// low. It carries an operation (write frame, read frame, flush, statistic
// query), the frame samples, a padding request flag and a statistic selector.
// Output: one result per command, shown for one cycle with out_valid high.
// The receiver cannot stall; results are never held back.
// Configuration: cfg_valid/cfg_ready with a register index and data. Index 0
// is the channel count, index 1 the ring capacity in frames. cfg_ready is
// always high; write only while no command is in flight.
// Result path: each command is held in the command queue, then the registered
// execute stage drives its result onto the ports.
// Throughput: one command per cycle. A two-entry command queue separates the
// front end from the execute stage, and the frame store has one write port
// and one registered read port, so consecutive reads and writes do not stall.
// Reset (synchronous, active low) empties the ring, clears the counters, sets
// the flush generation to one, the channel count to one and the capacity to
// 1024 frames (or the store depth if smaller). The frame store is not cleared.
module audio_frame_fifo import afifo_pkg::*; #(
  parameter int STORE_DEPTH  = 1024,
  parameter int MAX_CHANNELS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_operation,
  input  logic signed [15:0]    in_sample_0,
  input  logic signed [15:0]    in_sample_1,
  input  logic signed [15:0]    in_sample_2,
  input  logic signed [15:0]    in_sample_3,
  input  logic signed [15:0]    in_sample_4,
  input  logic signed [15:0]    in_sample_5,
  input  logic signed [15:0]    in_sample_6,
  input  logic signed [15:0]    in_sample_7,
  input  logic                  in_pad_req,
  input  logic [2:0]            in_stat_select,
  output logic                  out_valid,
  output logic                  out_accepted,
  output logic                  out_padded,
  output logic signed [15:0]    out_out_0,
  output logic signed [15:0]    out_out_1,
  output logic signed [15:0]    out_out_2,
  output logic signed [15:0]    out_out_3,
  output logic signed [15:0]    out_out_4,
  output logic signed [15:0]    out_out_5,
  output logic signed [15:0]    out_out_6,
  output logic signed [15:0]    out_out_7,
  output logic [OCC_W-1:0]      out_occupancy,
  output logic [STAT_W-1:0]     out_stat_value,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  frame_t in_samples;
  frame_t res_samples;
  cmd_t   cmd;
  logic   cmd_valid;

  // Gather the sample ports into one frame.
  assign in_samples[0] = in_sample_0;
  assign in_samples[1] = in_sample_1;
  assign in_samples[2] = in_sample_2;
  assign in_samples[3] = in_sample_3;
  assign in_samples[4] = in_sample_4;
  assign in_samples[5] = in_sample_5;
  assign in_samples[6] = in_sample_6;
  assign in_samples[7] = in_sample_7;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  afifo_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_samples     (in_samples),
    .in_pad_req     (in_pad_req),
    .in_stat_select (in_stat_select),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd)
  );

  afifo_back #(
    .STORE_DEPTH  (STORE_DEPTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .res_valid      (out_valid),
    .res_accepted   (out_accepted),
    .res_padded     (out_padded),
    .res_samples    (res_samples),
    .res_occupancy  (out_occupancy),
    .res_stat_value (out_stat_value)
  );

  // Split the result frame onto the sample ports.
  assign out_out_0 = res_samples[0];
  assign out_out_1 = res_samples[1];
  assign out_out_2 = res_samples[2];
  assign out_out_3 = res_samples[3];
  assign out_out_4 = res_samples[4];
  assign out_out_5 = res_samples[5];
  assign out_out_6 = res_samples[6];
  assign out_out_7 = res_samples[7];

endmodule
